[rtl/core/roll_tilt_scroll_detector_assert.svh]
// Assertion macros for the checker file rtsd_checker.sv.
`ifndef ROLL_TILT_SCROLL_DETECTOR_ASSERT_SVH
`define ROLL_TILT_SCROLL_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define RTSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtsd assertion failed");

// Next-cycle implication, disabled while reset is held.
`define RTSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtsd assertion failed");

// Next-cycle implication that stays live through reset.
`define RTSD_ASSERT_RST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rtsd reset assertion failed");

`endif

[rtl/core/rtsd_pkg.sv]
`default_nettype none

package rtsd_pkg;

  // Fixed field widths
  localparam int ROLL_W       = 17;
  localparam int TIME_W       = 32;
  localparam int STEP_W       = 2;
  localparam int MARGIN_W     = 6;
  localparam int LARGE_W      = 7;
  localparam int HOLD_W       = 16;
  localparam int REBASE_W     = 16;
  localparam int WEIGHT_W     = 25;
  localparam int WEIGHT_FRAC  = 24;
  localparam int BASE_W       = 40;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 25;

  // Parameter defaults
  localparam int ROLL_FRAC_BITS_DEF = 8;
  localparam int BASE_FRAC_BITS_DEF = 24;

  // Reset values
  localparam int BASE_RESET_DEG = 90;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(4);
  localparam logic [LARGE_W-1:0]  LARGE_RESET  = LARGE_W'(10);
  localparam logic [HOLD_W-1:0]   HOLD_RESET   = HOLD_W'(200);
  localparam logic [REBASE_W-1:0] REBASE_RESET = REBASE_W'(5000);
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(16777);
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = WEIGHT_W'(1) << WEIGHT_FRAC;

  typedef logic signed [STEP_W-1:0] step_t;
  localparam step_t STEP_NONE = 2'sb00;
  localparam step_t STEP_UP   = 2'sb01;
  localparam step_t STEP_DOWN = 2'sb11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MARGIN = 3'd0,
    CFG_LARGE  = 3'd1,
    CFG_HOLD   = 3'd2,
    CFG_REBASE = 3'd3,
    CFG_WEIGHT = 3'd4
  } cfg_idx_t;

endpackage

`default_nettype wire

[rtl/core/roll_tilt_scroll_detector.sv]
// Roll tilt scroll detector.
// Input channel (in_valid/in_ready): one request per orientation sample, carrying
// in_roll_deg (signed Q9.8 degrees) and in_now_ms (free-running ms time stamp).
// Output channel (out_valid/out_ready): exactly one scroll_step per request,
// +1, -1 or 0, in request order.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 margin,
// 1 large band, 2 hold, 3 rebase, 4 weight); other indexes are dropped. Write
// only while no request is in flight.
// Pipeline: input register, then compare/multiply/update logic that
// also commits the baseline and last-event time, then an output register.
// Throughput is one request per cycle while the receiver takes results, as the
// baseline update loop runs through the update logic into base_r alone.
// When the receiver stalls, the result holds in the output register, one more
// request can sit in the input register, and then in_ready drops.
// Reset (synchronous, rst_n low) empties both registers, restores the register
// defaults, sets the baseline to 90 degrees and the last-event time to zero.
`default_nettype none

module roll_tilt_scroll_detector #(
  parameter int ROLL_FRAC_BITS = rtsd_pkg::ROLL_FRAC_BITS_DEF,
  parameter int BASE_FRAC_BITS = rtsd_pkg::BASE_FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [rtsd_pkg::ROLL_W-1:0] in_roll_deg,
  input  wire logic [rtsd_pkg::TIME_W-1:0]        in_now_ms,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output rtsd_pkg::step_t                        out_scroll_step,
  input  wire logic                              cfg_we,
  input  wire logic [rtsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rtsd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rtsd_pkg::*;

  // Sample scaled into the baseline format, then the difference width.
  localparam int SHIFT    = BASE_FRAC_BITS - ROLL_FRAC_BITS;
  localparam int SAMPLE_W = ROLL_W + SHIFT;
  localparam int DIFF_W   = (SAMPLE_W > BASE_W ? SAMPLE_W : BASE_W) + 1;
  localparam int WHOLE_W  = DIFF_W - BASE_FRAC_BITS;
  // In the small band |d| < 2^(B+6), so the multiplier sees a narrow d.
  localparam int SMALL_W  = BASE_FRAC_BITS + MARGIN_W + 1;
  localparam int PROD_W   = WEIGHT_W + 1 + SMALL_W;
  localparam logic signed [BASE_W-1:0] BASE_RESET =
    BASE_W'(BASE_RESET_DEG) << BASE_FRAC_BITS;

  // Configuration registers
  logic [MARGIN_W-1:0] margin_r;
  logic [LARGE_W-1:0]  large_r;
  logic [HOLD_W-1:0]   hold_r;
  logic [REBASE_W-1:0] rebase_r;
  logic [WEIGHT_W-1:0] weight_r;

  // Input stage
  logic                     s1_valid_r;
  logic signed [ROLL_W-1:0] s1_roll_r;
  logic [TIME_W-1:0]        s1_now_r;

  // State
  logic signed [BASE_W-1:0] base_r, base_nxt;
  logic [TIME_W-1:0]        last_r, last_nxt;

  // Output stage
  logic  out_valid_r;
  step_t out_step_r, step_nxt;

  logic s1_fire;

  logic signed [SAMPLE_W-1:0] sample;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [WHOLE_W-1:0]  whole;
  logic [WHOLE_W-1:0]         mag;
  logic                       round_up;
  logic                       in_small, in_large;
  logic [TIME_W-1:0]          elapsed;
  logic                       hold_due, rebase_due;
  logic [WEIGHT_W-1:0]        w_sat;
  logic signed [SMALL_W-1:0]  d_small;
  logic signed [PROD_W-1:0]   prod, prod_rnd;
  logic signed [SMALL_W-1:0]  adj;

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  assign out_valid       = out_valid_r;
  assign out_scroll_step = out_step_r;

  // Deviation: difference truncated toward zero to whole degrees.
  assign sample   = $signed({s1_roll_r, {SHIFT{1'b0}}});
  assign diff     = DIFF_W'(sample) - DIFF_W'(base_r);
  assign round_up = diff[DIFF_W-1] && (|diff[BASE_FRAC_BITS-1:0]);
  assign whole    = diff[DIFF_W-1:BASE_FRAC_BITS]
                    + $signed({{(WHOLE_W-1){1'b0}}, round_up});
  assign mag      = whole[WHOLE_W-1] ? WHOLE_W'(-whole) : WHOLE_W'(whole);

  assign in_small = mag < {{(WHOLE_W-MARGIN_W){1'b0}}, margin_r};
  assign in_large = mag > {{(WHOLE_W-LARGE_W){1'b0}}, large_r};

  // Wrapping elapsed time
  assign elapsed    = s1_now_r - last_r;
  assign hold_due   = elapsed > {{(TIME_W-HOLD_W){1'b0}}, hold_r};
  assign rebase_due = elapsed > {{(TIME_W-REBASE_W){1'b0}}, rebase_r};

  // EWMA step: (w * d) / 2^24 toward zero; weight saturates at 1.0.
  assign w_sat    = (weight_r > WEIGHT_ONE) ? WEIGHT_ONE : weight_r;
  assign d_small  = diff[SMALL_W-1:0];
  assign prod     = $signed({1'b0, w_sat}) * d_small;
  assign prod_rnd = prod + $signed({{(PROD_W-WEIGHT_FRAC){1'b0}},
                                    {WEIGHT_FRAC{prod[PROD_W-1]}}});
  assign adj      = prod_rnd[WEIGHT_FRAC +: SMALL_W];

  always_comb begin
    base_nxt = base_r;
    last_nxt = last_r;
    step_nxt = STEP_NONE;
    if (in_small) begin
      base_nxt = base_r + BASE_W'(adj);
      last_nxt = s1_now_r;
    end else if (in_large) begin
      if (rebase_due) begin
        base_nxt = BASE_W'(sample);
        last_nxt = s1_now_r;
      end
    end else if (hold_due) begin
      last_nxt = s1_now_r;
      // zero deviation here counts as downward
      step_nxt = (!whole[WHOLE_W-1] && (|whole)) ? STEP_UP : STEP_DOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r    <= MARGIN_RESET;
      large_r     <= LARGE_RESET;
      hold_r      <= HOLD_RESET;
      rebase_r    <= REBASE_RESET;
      weight_r    <= WEIGHT_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      base_r      <= BASE_RESET;
      last_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MARGIN: margin_r <= cfg_data[MARGIN_W-1:0];
          CFG_LARGE:  large_r  <= cfg_data[LARGE_W-1:0];
          CFG_HOLD:   hold_r   <= cfg_data[HOLD_W-1:0];
          CFG_REBASE: rebase_r <= cfg_data[REBASE_W-1:0];
          CFG_WEIGHT: weight_r <= cfg_data[WEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
        base_r      <= base_nxt;
        last_r      <= last_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_roll_r <= in_roll_deg;
      s1_now_r  <= in_now_ms;
    end
    if (s1_fire) begin
      out_step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/rtsd_checker.sv]
`default_nettype none
`include "roll_tilt_scroll_detector_assert.svh"

module rtsd_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_valid,
  input wire logic            in_ready,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire rtsd_pkg::step_t out_scroll_step
);
  import rtsd_pkg::*;

  logic step_legal;
  logic out_stall;

  assign step_legal = (out_scroll_step == STEP_NONE) || (out_scroll_step == STEP_UP) ||
                      (out_scroll_step == STEP_DOWN);
  assign out_stall  = out_valid && !out_ready;

  // Only the three legal step codes ever leave the block.
  `RTSD_ASSERT_NOW(a_step_code, clk, rst_n, out_valid, step_legal)

  // Input side backs up only behind a stalled output.
  `RTSD_ASSERT_NOW(a_ready_backpressure, clk, rst_n, !in_ready, out_stall)

  // A stalled result stays put.
  `RTSD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, (out_valid && $stable(out_scroll_step)))

  // Reset empties the pipeline.
  `RTSD_ASSERT_RST(a_reset_empty, clk, !rst_n, (!out_valid && in_ready))

endmodule

bind roll_tilt_scroll_detector rtsd_checker u_rtsd_checker (.*);

`default_nettype wire
